### design/grid_min_cost_path_defines.svh
// Assertion macros used by the top-level design file
`ifndef GRID_MIN_COST_PATH_DEFINES_SVH
`define GRID_MIN_COST_PATH_DEFINES_SVH

// checked only out of reset
`define GMCP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GMCP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/gmcp_pkg.sv
package gmcp_pkg;

  localparam int MAX_COLS  = 256;
  localparam int MAX_ROWS  = 256;
  localparam int COST_BITS = 16;
  localparam int SUM_W     = 26;
  localparam int PATH_W    = 25;
  localparam int SIZE_W    = 9;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [COST_BITS-1:0] cost_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_W-1:0]     row_t;

  localparam cfg_idx_t REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_GRID_COLS = CFG_IDX_W'(1);

  // whether the cell being worked on is in the first row or first column
  typedef struct packed {
    logic first_row;
    logic first_col;
  } pos_t;

  // zero reads as one, anything above the maximum as the maximum
  function automatic size_t clamp_size(input size_t v, input size_t maxv);
    size_t res;
    if (v == size_t'(0)) begin
      res = size_t'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

### design/gmcp_line_store.sv
module gmcp_line_store (
  input  logic                clk,
  input  logic                we,
  input  gmcp_pkg::col_t      waddr,
  input  gmcp_pkg::sum_t      wdata,
  input  logic                re,
  input  gmcp_pkg::col_t      raddr,
  output gmcp_pkg::sum_t      rdata
);

  gmcp_pkg::sum_t mem [gmcp_pkg::MAX_COLS];
  gmcp_pkg::sum_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/gmcp_cell_calc.sv
module gmcp_cell_calc (
  input  gmcp_pkg::cost_t cost,
  input  gmcp_pkg::sum_t  left,
  input  gmcp_pkg::sum_t  diag,
  input  gmcp_pkg::sum_t  up,
  input  gmcp_pkg::pos_t  pos,
  output gmcp_pkg::sum_t  val
);

  gmcp_pkg::sum_t cost_ext;
  gmcp_pkg::sum_t min_lu;
  gmcp_pkg::sum_t min3;
  gmcp_pkg::sum_t base;

  assign cost_ext = gmcp_pkg::SUM_W'(cost);
  assign min_lu   = (up < left) ? up : left;
  assign min3     = (diag < min_lu) ? diag : min_lu;

  always_comb begin
    unique case ({pos.first_row, pos.first_col})
      2'b11:   base = '0;
      2'b10:   base = left;
      2'b01:   base = up;
      default: base = min3;
    endcase
  end

  assign val = base + cost_ext;

endmodule

### design/grid_min_cost_path.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    in_cell_cost[15:0]
// out_      output     out_valid/out_ready  out_path_cost[24:0]
// cfg_      input      cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[8:0]
//
// One cell per cycle sustained while no result is held: the line store is read one column ahead, so
// each cell costs a single pass through the min/add in the input register stage.
// The last cell's cost is registered on acceptance, then its path cost in the output register.
// Synchronous active-low reset: grid size 1x1, counters and costs at the origin.
// A held result stalls only the last cell of the next grid; other cells pass.
`include "grid_min_cost_path_defines.svh"

module grid_min_cost_path (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [gmcp_pkg::COST_BITS-1:0]      in_cell_cost,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [gmcp_pkg::PATH_W-1:0]         out_path_cost,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmcp_pkg::SIZE_W-1:0]         cfg_data
);

  gmcp_pkg::size_t grid_rows_r, grid_cols_r;
  gmcp_pkg::size_t rows_eff, cols_eff;
  gmcp_pkg::col_t  col_r, col_nxt;
  gmcp_pkg::row_t  row_r, row_nxt;
  gmcp_pkg::sum_t  left_r, diag_r;
  logic            in_valid_r;
  gmcp_pkg::cost_t in_cost_r;
  logic            out_valid_r;
  logic [gmcp_pkg::PATH_W-1:0] out_path_cost_r;

  logic            last_col, last_row, emit, proc;
  gmcp_pkg::pos_t  pos;
  gmcp_pkg::sum_t  rd_up, up, val;

  assign rows_eff = gmcp_pkg::clamp_size(grid_rows_r, gmcp_pkg::SIZE_W'(gmcp_pkg::MAX_ROWS));
  assign cols_eff = gmcp_pkg::clamp_size(grid_cols_r, gmcp_pkg::SIZE_W'(gmcp_pkg::MAX_COLS));

  assign last_col = (gmcp_pkg::SIZE_W'(col_r) + gmcp_pkg::SIZE_W'(1)) == cols_eff;
  assign last_row = (gmcp_pkg::SIZE_W'(row_r) + gmcp_pkg::SIZE_W'(1)) == rows_eff;
  assign emit     = last_col && last_row;
  assign proc     = in_valid_r && (!emit || !out_valid_r || out_ready);

  assign in_ready  = !in_valid_r || proc;
  assign cfg_ready = 1'b1;

  assign col_nxt = last_col ? '0 : col_r + gmcp_pkg::COL_W'(1);
  assign row_nxt = last_row ? '0 : row_r + gmcp_pkg::ROW_W'(1);

  assign pos.first_row = (row_r == '0);
  assign pos.first_col = (col_r == '0);

  // single column: the cell above is the one just done
  assign up = (cols_eff == gmcp_pkg::SIZE_W'(1)) ? left_r : rd_up;

  gmcp_line_store u_line_store (
    .clk   (clk),
    .we    (proc),
    .waddr (col_r),
    .wdata (val),
    .re    (proc),
    .raddr (col_nxt),
    .rdata (rd_up)
  );

  gmcp_cell_calc u_cell_calc (
    .cost (in_cost_r),
    .left (left_r),
    .diag (diag_r),
    .up   (up),
    .pos  (pos),
    .val  (val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= gmcp_pkg::SIZE_W'(1);
      grid_cols_r <= gmcp_pkg::SIZE_W'(1);
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      diag_r      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == gmcp_pkg::REG_GRID_ROWS) begin
        grid_rows_r <= cfg_data;
      end
      if (cfg_index == gmcp_pkg::REG_GRID_COLS) begin
        grid_cols_r <= cfg_data;
      end
      if (cfg_index == gmcp_pkg::REG_GRID_ROWS || cfg_index == gmcp_pkg::REG_GRID_COLS) begin
        col_r  <= '0;
        row_r  <= '0;
        left_r <= '0;
        diag_r <= '0;
      end
    end else if (proc) begin
      col_r <= col_nxt;
      if (last_col) begin
        row_r <= row_nxt;
      end
      if (emit) begin
        left_r <= '0;
        diag_r <= '0;
      end else begin
        left_r <= val;
        if (!pos.first_row) begin
          diag_r <= up;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (proc) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cost_r <= in_cell_cost;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      out_path_cost_r <= val[gmcp_pkg::PATH_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_path_cost = out_path_cost_r;

  `GMCP_ASSERT(a_col_in_range, (gmcp_pkg::SIZE_W'(col_r) < cols_eff), "column counter out of range")
  `GMCP_ASSERT(a_row_in_range, (gmcp_pkg::SIZE_W'(row_r) < rows_eff), "row counter out of range")
  `GMCP_ASSERT(a_emit_restarts, (proc && emit && !cfg_valid) |=> (out_valid_r && col_r == '0 && row_r == '0 && left_r == '0), "grid end did not restart")
  `GMCP_ASSERT(a_advance, (proc && !emit && !cfg_valid) |=> !$stable({row_r, col_r}), "position did not advance")

endmodule
